[hw/rtl/fixed_string_match_counter_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the fixed string match counter checks
// Shared macro forms: one that skips reset cycles, one that is always on.
// ----------------------------------------------------------------------------
`ifndef FIXED_STRING_MATCH_COUNTER_TOP_ASSERT_SVH
`define FIXED_STRING_MATCH_COUNTER_TOP_ASSERT_SVH

// Checked only outside reset.
`define FSMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define FSMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/fsmc_pkg.sv]
// ----------------------------------------------------------------------------
// fsmc_pkg
// Types and constants shared by the fixed string match counter.
// ----------------------------------------------------------------------------
package fsmc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 5;
  localparam int CFG_W       = 64;
  localparam int COUNT_W     = 32;
  localparam int IDX_W       = 2;
  localparam int PAT_BYTES   = 16;
  localparam int PAT_SEL_W   = 4;

  typedef enum logic [IDX_W-1:0] {
    REG_PATTERN_LENGTH = 2'd0,
    REG_PATTERN_LOW    = 2'd1,
    REG_PATTERN_HIGH   = 2'd2
  } cfg_reg_t;

  // Per-cell compare setup: whether the cell's position is part of the
  // pattern and which pattern byte must sit there for a match.
  typedef struct packed {
    logic              care;
    logic [BYTE_W-1:0] expect_byte;
  } lane_cfg_t;

endpackage

[hw/rtl/fsmc_if.sv]
// ----------------------------------------------------------------------------
// fsmc channel interfaces
// Valid/ready channels for text bytes in and match results out.
// ----------------------------------------------------------------------------
interface text_if
  import fsmc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface result_if
  import fsmc_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               match_ends_here;
  logic [COUNT_W-1:0] match_total;
  logic               text_done;

  modport source (output valid, output match_ends_here, output match_total,
                  output text_done, input ready);
  modport sink   (input valid, input match_ends_here, input match_total,
                  input text_done, output ready);
endinterface

[hw/rtl/fsmc_cfg.sv]
// ----------------------------------------------------------------------------
// fsmc_cfg
// Pattern registers and per-cell compare setup derived from them.
// ----------------------------------------------------------------------------
module fsmc_cfg
  import fsmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output lane_cfg_t            lane [MAX_PATTERN]
);

  logic [LEN_W-1:0] pattern_length;
  logic [CFG_W-1:0] pattern_bytes_low;
  logic [CFG_W-1:0] pattern_bytes_high;

  logic [LEN_W-1:0]  len_eff;
  logic [BYTE_W-1:0] pat_bytes [PAT_BYTES];
  lane_cfg_t         lane_next [MAX_PATTERN];

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length     <= LEN_W'(1);
      pattern_bytes_low  <= '0;
      pattern_bytes_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: pattern_length     <= cfg_data[LEN_W-1:0];
        REG_PATTERN_LOW:    pattern_bytes_low  <= cfg_data;
        REG_PATTERN_HIGH:   pattern_bytes_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign len_eff = (pattern_length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                          : pattern_length;

  always_comb begin
    for (int k = 0; k < PAT_BYTES; k++) begin
      if (k < PAT_BYTES / 2) begin
        pat_bytes[k] = pattern_bytes_low[k*BYTE_W +: BYTE_W];
      end else begin
        pat_bytes[k] = pattern_bytes_high[(k - PAT_BYTES/2)*BYTE_W +: BYTE_W];
      end
    end
  end

  // Window position j (0 = newest) must equal pattern byte len-1-j.
  always_comb begin
    logic [LEN_W-1:0] sel;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      sel                       = len_eff - LEN_W'(1) - LEN_W'(j);
      lane_next[j].care         = LEN_W'(j) < len_eff;
      lane_next[j].expect_byte  = pat_bytes[sel[PAT_SEL_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    lane <= lane_next;
  end

endmodule

[hw/rtl/fsmc_cell.sv]
// ----------------------------------------------------------------------------
// fsmc_cell
// One window position: holds a text byte and its valid bit, passes both on.
// ----------------------------------------------------------------------------
module fsmc_cell
  import fsmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              valid_in,
  input  lane_cfg_t         lane,
  output logic [BYTE_W-1:0] byte_out,
  output logic              valid_out,
  output logic              ok
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (shift) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_out <= byte_in;
    end
  end

  // Positions outside the pattern never block a match.
  assign ok = !lane.care || (valid_out && (byte_out == lane.expect_byte));

endmodule

[hw/rtl/fsmc_count.sv]
// ----------------------------------------------------------------------------
// fsmc_count
// Saturating match counter and result output register.
// ----------------------------------------------------------------------------
module fsmc_count
  import fsmc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_last,
  input  logic        hit,
  output logic        take,
  result_if.source    result_out
);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;

  assign take = in_valid && (!result_out.valid || result_out.ready);

  assign count_next = (hit && (count != '1)) ? count + COUNT_W'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count            <= '0;
      result_out.valid <= 1'b0;
    end else begin
      if (take) begin
        count            <= in_last ? '0 : count_next;
        result_out.valid <= 1'b1;
      end else if (result_out.ready) begin
        result_out.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result_out.match_ends_here <= hit;
      result_out.match_total     <= count_next;
      result_out.text_done       <= in_last;
    end
  end

endmodule

[hw/rtl/fixed_string_match_counter_top.sv]
// ----------------------------------------------------------------------------
// fixed_string_match_counter_top
// Counts overlapping matches of a 1..16 byte pattern in a byte stream.
// ----------------------------------------------------------------------------
//  channel     dir  beat
//  text_in     in   text_byte, end_of_text
//  result_out  out  match_ends_here, match_total, text_done
//  cfg port    in   cfg_we, cfg_index, cfg_data (write only)
//
//  One byte per cycle unless result_out stalls; a byte passes the cell row
//  and then the output register. The cell row shifts on every accepted byte;
//  compare and AND over cells are combinational; the counter updates on take.
//  Reset (rst, synchronous) empties the window and clears the count.
//  A stalled result holds in the output register; text_in backs up once
//  the single compare stage behind the cell row is full.
// ----------------------------------------------------------------------------
module fixed_string_match_counter_top
  import fsmc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  text_if.sink             text_in,
  result_if.source         result_out
);

  lane_cfg_t         lane      [MAX_PATTERN];
  logic [BYTE_W-1:0] cell_byte [MAX_PATTERN];
  logic              cell_valid[MAX_PATTERN];
  logic              cell_ok   [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] ok_vec;

  logic accept;
  logic restart;
  logic s1_valid;
  logic s1_last;
  logic hit;
  logic take;

  fsmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lane      (lane)
  );

  assign text_in.ready = !s1_valid || take;
  assign accept        = text_in.valid && text_in.ready;

  // After a final byte, the next beat starts a fresh text: older cells go invalid.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    if (j == 0) begin : g_head
      fsmc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (accept),
        .byte_in   (text_in.text_byte),
        .valid_in  (1'b1),
        .lane      (lane[j]),
        .byte_out  (cell_byte[j]),
        .valid_out (cell_valid[j]),
        .ok        (cell_ok[j])
      );
    end else begin : g_body
      fsmc_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .shift     (accept),
        .byte_in   (cell_byte[j-1]),
        .valid_in  (cell_valid[j-1] && !restart),
        .lane      (lane[j]),
        .byte_out  (cell_byte[j]),
        .valid_out (cell_valid[j]),
        .ok        (cell_ok[j])
      );
    end
    assign ok_vec[j] = cell_ok[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      restart  <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        restart  <= text_in.end_of_text;
        s1_valid <= 1'b1;
      end else if (take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_last <= text_in.end_of_text;
    end
  end

  // Zero length leaves every position out of the pattern: no match.
  assign hit = lane[0].care && (&ok_vec);

  fsmc_count u_count (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s1_valid),
    .in_last    (s1_last),
    .hit        (hit),
    .take       (take),
    .result_out (result_out)
  );

endmodule

[hw/rtl/fsmc_checker.sv]
// ----------------------------------------------------------------------------
// fsmc_checker
// Port-level checks on the match counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_string_match_counter_top_assert.svh"

module fsmc_checker
  import fsmc_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               match_ends_here,
  input logic [COUNT_W-1:0] match_total,
  input logic               text_done
);

  logic               out_beat;
  logic               have_prev;
  logic               prev_done;
  logic [COUNT_W-1:0] prev_total;
  logic               same_text;

  assign out_beat  = out_valid && out_ready;
  assign same_text = have_prev && !prev_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
    end else if (out_beat) begin
      have_prev <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_done  <= text_done;
      prev_total <= match_total;
    end
  end

  `FSMC_ASSERT_ALWAYS(a_idle_after_reset, rst |=> !out_valid, "result valid right after reset")
  `FSMC_ASSERT(a_hold_on_stall, (out_valid && !out_ready) |=> out_valid, "stalled result dropped")
  `FSMC_ASSERT(a_hit_counted, (out_valid && match_ends_here) |-> (match_total != '0), "match with zero total")
  `FSMC_ASSERT(a_total_step, (out_beat && same_text) |-> (match_ends_here ? ((match_total == prev_total + COUNT_W'(1)) || (match_total == '1)) : (match_total == prev_total)), "total moved wrongly")

endmodule

bind fixed_string_match_counter_top fsmc_checker u_fsmc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result_out.valid),
  .out_ready       (result_out.ready),
  .match_ends_here (result_out.match_ends_here),
  .match_total     (result_out.match_total),
  .text_done       (result_out.text_done)
);
